// ===== src/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants and types of the range maximum segment tree unit.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int LEAF_MAX   = 1024;
   localparam int IDX_W      = $clog2(LEAF_MAX);
   localparam int NODE_COUNT = 2 * LEAF_MAX - 1;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int VAL_W      = 31;
   localparam int MAX_W      = VAL_W + 1;
   localparam int SIZE_W     = 11;
   localparam int STK_DEPTH  = 16;
   localparam int SP_W       = $clog2(STK_DEPTH);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // one input word, unpacked
   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] position;
      logic [VAL_W-1:0] new_value;
      logic [IDX_W-1:0] range_low;
      logic [IDX_W-1:0] range_high;
   } req_type;

   // one result word
   typedef struct packed {
      logic                    valid;
      logic signed [MAX_W-1:0] max_value;
      logic                    range_ok;
   } res_type;

   // node memory access: one write and one read port
   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [VAL_W-1:0]  wdata;
      logic              re;
      logic [NODE_W-1:0] raddr;
   } ram_req_type;

endpackage

// ===== src/rmst_node_ram.sv =====
// ----------------------------------------------------------------------------
// rmst_node_ram
// Node store of the tree: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rmst_node_ram
   import rmst_pkg::*;
(
   input  logic             clock,
   input  ram_req_type      ram_req,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem [NODE_COUNT];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rmst_walker.sv =====
// ----------------------------------------------------------------------------
// rmst_walker
// Tree walk sequencer: clearing pass, point write and range query walks.
// ----------------------------------------------------------------------------
module rmst_walker
   import rmst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   input  logic [IDX_W-1:0]  last_pos,
   output res_type           res,
   input  logic              res_ready,
   output ram_req_type       ram_req,
   input  logic [VAL_W-1:0]  rd_data
);

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WDESC = 3'd2;
   localparam logic [2:0] S_WASC  = 3'd3;
   localparam logic [2:0] S_QWALK = 3'd4;
   localparam logic [2:0] S_QFIN  = 3'd5;
   localparam logic [2:0] S_RES   = 3'd6;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W-1:0] ROOT      = '0;
   localparam logic [NODE_W-1:0] ONE       = NODE_W'(1);

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] clr_addr_ff, clr_addr_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0]  seg_s_ff, seg_s_in;
   logic [IDX_W-1:0]  seg_e_ff, seg_e_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]  qlo_ff, qlo_in;
   logic [IDX_W-1:0]  qhi_ff, qhi_in;
   logic [VAL_W-1:0]  best_ff, best_in;
   logic              pend_ff, pend_in;
   logic              ok_ff, ok_in;
   logic [SP_W-1:0]   sp_ff, sp_in;

   logic [NODE_W-1:0] stk_node_ff [STK_DEPTH];
   logic [IDX_W-1:0]  stk_s_ff    [STK_DEPTH];
   logic [IDX_W-1:0]  stk_e_ff    [STK_DEPTH];
   logic              push;
   logic [SP_W-1:0]   top_idx;

   logic [IDX_W-1:0]  mid;
   logic [NODE_W-1:0] left_child, right_child, parent, sibling, par_sibling;
   logic [VAL_W-1:0]  merged, acc;
   logic              covered, disjoint;

   always_comb begin
      mid         = seg_s_ff + ((seg_e_ff - seg_s_ff) >> 1);
      left_child  = {node_ff[NODE_W-2:0], 1'b1};
      right_child = left_child + ONE;
      parent      = (node_ff - ONE) >> 1;
      sibling     = node_ff[0] ? node_ff + ONE : node_ff - ONE;
      par_sibling = parent[0] ? parent + ONE : parent - ONE;
      merged      = (rd_data > val_ff) ? rd_data : val_ff;
      acc         = (pend_ff && rd_data > best_ff) ? rd_data : best_ff;
      covered     = (qlo_ff <= seg_s_ff) && (qhi_ff >= seg_e_ff);
      disjoint    = (seg_e_ff < qlo_ff) || (seg_s_ff > qhi_ff);
      top_idx     = sp_ff - SP_W'(1);
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      node_in     = node_ff;
      seg_s_in    = seg_s_ff;
      seg_e_in    = seg_e_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      qlo_in      = qlo_ff;
      qhi_in      = qhi_ff;
      best_in     = best_ff;
      pend_in     = 1'b0;
      ok_in       = ok_ff;
      sp_in       = sp_ff;
      push        = 1'b0;
      ram_req     = '0;

      case (state_ff)
         S_CLR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_addr_ff;
            clr_addr_in   = clr_addr_ff + ONE;
            if (clr_addr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               node_in  = ROOT;
               seg_s_in = '0;
               seg_e_in = last_pos;
               pos_in   = req.position;
               val_in   = req.new_value;
               qlo_in   = req.range_low;
               qhi_in   = req.range_high;
               sp_in    = '0;
               best_in  = '0;
               ok_in    = 1'b1;
               if (req.mode == MODE_WRITE) begin
                  // drop writes beyond the tree
                  if (req.position <= last_pos) begin
                     state_in = S_WDESC;
                  end
               end else if (req.range_low > req.range_high || req.range_high > last_pos) begin
                  ok_in    = 1'b0;
                  state_in = S_RES;
               end else begin
                  state_in = S_QWALK;
               end
            end
         end
         S_WDESC: begin
            if (seg_s_ff == seg_e_ff) begin
               // leaf reached: store it and, unless it is the root, fetch its sibling
               ram_req.we    = 1'b1;
               ram_req.waddr = node_ff;
               ram_req.wdata = val_ff;
               if (node_ff == ROOT) begin
                  state_in = S_IDLE;
               end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = sibling;
                  state_in      = S_WASC;
               end
            end else if (pos_ff <= mid) begin
               node_in  = left_child;
               seg_e_in = mid;
            end else begin
               node_in  = right_child;
               seg_s_in = mid + IDX_W'(1);
            end
         end
         S_WASC: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = parent;
            ram_req.wdata = merged;
            node_in       = parent;
            val_in        = merged;
            if (parent == ROOT) begin
               state_in = S_IDLE;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = par_sibling;
            end
         end
         S_QWALK: begin
            best_in = acc;
            if (covered || disjoint) begin
               if (covered) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = node_ff;
                  pend_in       = 1'b1;
               end
               if (sp_ff == '0) begin
                  state_in = S_QFIN;
               end else begin
                  node_in  = stk_node_ff[top_idx];
                  seg_s_in = stk_s_ff[top_idx];
                  seg_e_in = stk_e_ff[top_idx];
                  sp_in    = top_idx;
               end
            end else begin
               // partial overlap: park the right half, descend left
               push     = 1'b1;
               sp_in    = sp_ff + SP_W'(1);
               node_in  = left_child;
               seg_e_in = mid;
            end
         end
         S_QFIN: begin
            best_in  = acc;
            state_in = S_RES;
         end
         S_RES: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
         sp_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         sp_ff       <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      seg_s_ff <= seg_s_in;
      seg_e_ff <= seg_e_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      qlo_ff   <= qlo_in;
      qhi_ff   <= qhi_in;
      best_ff  <= best_in;
      ok_ff    <= ok_in;
      if (push) begin
         stk_node_ff[sp_ff] <= right_child;
         stk_s_ff[sp_ff]    <= mid + IDX_W'(1);
         stk_e_ff[sp_ff]    <= seg_e_ff;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign res.valid     = (state_ff == S_RES);
   assign res.max_value = ok_ff ? {1'b0, best_ff} : '1;
   assign res.range_ok  = ok_ff;

   // the walk never reads the entry it writes in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
      else $error("node read and write collide");

   // a query walk parks at most one node per tree level
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(IDX_W))
      else $error("query stack overflow");

   // the clearing pass writes zeros only
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> (ram_req.we && ram_req.wdata == '0))
      else $error("clearing pass wrote data");

   // a write to the root ends the ascent
   a_asc_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WASC && ram_req.waddr == ROOT) |=> (state_ff == S_IDLE))
      else $error("ascent continued past root");

endmodule

// ===== src/range_max_segment_tree_unit.sv =====
// ----------------------------------------------------------------------------
// range_max_segment_tree_unit
// Range maximum segment tree with point writes over up to 1024 leaves.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                    | handshake
//  --------+-----------+--------------------------------------------+----------------
//  req     | in        | tuser: mode; tdata: position, new_value,   | tvalid / tready
//          |           |        range_low, range_high               |
//  rsp     | out       | tuser: range_ok; tdata: max_value          | tvalid / tready
//  csr     | in        | data: size_in_use                          | valid / ready
//
//  A point write descends one level at a time to the leaf, then climbs
//  one level at a time back to the root, since the node memory reads one
//  sibling and writes one parent at each step of the climb.
//  A query visits at most about four nodes per tree level; a bad range
//  goes straight to the result and an out-of-range write starts no walk.
//  After reset a clearing pass zeroes all 2047 nodes of the node memory;
//  no word is accepted during it, configuration writes are taken throughout.
//  A result waits in the output register; the next word is accepted while
//  it waits, and the walker stalls only when a second result is ready.
//
module range_max_segment_tree_unit
   import rmst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // position, new_value, range_low, range_high, zero pad
   input  logic [0:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // max_value
   output logic [0:0]   rsp_tuser,   // range_ok
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [SIZE_W-1:0] csr_data // size_in_use
);

   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  last_pos;
   req_type           req;
   res_type           res;
   logic              res_ready;
   ram_req_type       ram_req;
   logic [VAL_W-1:0]  rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MAX_W-1:0]  rsp_max_ff;
   logic              rsp_ok_ff;

   // unpack the request word
   assign req.mode       = req_tuser[0];
   assign req.position   = req_tdata[9:0];
   assign req.new_value  = req_tdata[40:10];
   assign req.range_low  = req_tdata[50:41];
   assign req.range_high = req_tdata[60:51];

   // size register; clamp a zero size to one leaf and a large one to the maximum
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(LEAF_MAX);
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         last_pos = '0;
      end else if (size_ff > SIZE_W'(LEAF_MAX)) begin
         last_pos = IDX_W'(LEAF_MAX - 1);
      end else begin
         last_pos = IDX_W'(size_ff - SIZE_W'(1));
      end
   end

   rmst_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .last_pos  (last_pos),
      .res       (res),
      .res_ready (res_ready),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   rmst_node_ram u_node_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // output register: load when empty or being drained, hold otherwise
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_ready) begin
         rsp_max_ff <= res.max_value;
         rsp_ok_ff  <= res.range_ok;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_max_ff;
   assign rsp_tuser[0] = rsp_ok_ff;

endmodule

// ===== tb/sv/range_max_segment_tree_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_segment_tree_checker
// Watches the request, result and register channels and keeps its own copy
// of the maximum tree. It predicts each query answer and compares the
// results in order.
// ----------------------------------------------------------------------------
module range_max_segment_tree_checker
   import rmst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic [0:0]        req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [31:0]       rsp_tdata,
   input  logic [0:0]        rsp_tuser,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data,
   output int                error_count,
   output int                pending_answers
);

   typedef struct {
      logic signed [MAX_W-1:0] max_value;
      logic                    range_ok;
   } range_answer_type;

   range_answer_type  answer_q[$];
   logic [VAL_W-1:0]  node_max [NODE_COUNT];
   logic [SIZE_W-1:0] size_reg;

   function automatic int unsigned live_leaves();
      if (size_reg == '0) return 1;
      if (size_reg > SIZE_W'(LEAF_MAX)) return LEAF_MAX;
      return 32'(size_reg);
   endfunction

   // maximum over lo..hi within the node covering s..e; -1 where nothing overlaps
   function automatic longint span_max(input int unsigned s, input int unsigned e,
                                       input int unsigned lo, input int unsigned hi,
                                       input int unsigned node);
      int unsigned mid;
      longint      left_max;
      longint      right_max;
      if (node >= NODE_COUNT) return -1;
      if (lo <= s && hi >= e) return longint'(node_max[node]);
      if (e < lo || s > hi) return -1;
      mid       = s + (e - s) / 2;
      left_max  = span_max(s, mid, lo, hi, 2 * node + 1);
      right_max = span_max(mid + 1, e, lo, hi, 2 * node + 2);
      return (left_max > right_max) ? left_max : right_max;
   endfunction

   function automatic void store_leaf(input int unsigned s, input int unsigned e,
                                      input int unsigned pos, input logic [VAL_W-1:0] value,
                                      input int unsigned node);
      int unsigned mid;
      int unsigned lch;
      int unsigned rch;
      if (node >= NODE_COUNT) return;
      if (pos < s || pos > e) return;
      if (s == e) begin
         node_max[node] = value;
         return;
      end
      mid = s + (e - s) / 2;
      lch = 2 * node + 1;
      rch = 2 * node + 2;
      if (pos <= mid) store_leaf(s, mid, pos, value, lch);
      else store_leaf(mid + 1, e, pos, value, rch);
      if (rch < NODE_COUNT)
         node_max[node] = (node_max[lch] > node_max[rch]) ? node_max[lch] : node_max[rch];
   endfunction

   function automatic void apply_word(input req_type word);
      int unsigned      leaves;
      int unsigned      pos;
      int unsigned      lo;
      int unsigned      hi;
      longint           best;
      range_answer_type answer;
      leaves = live_leaves();
      pos    = 32'(word.position);
      lo     = 32'(word.range_low);
      hi     = 32'(word.range_high);
      if (word.mode == MODE_WRITE) begin
         if (pos < leaves) store_leaf(0, leaves - 1, pos, word.new_value, 0);
         return;
      end
      if (lo > hi || hi >= leaves) begin
         answer.max_value = -1;
         answer.range_ok  = 1'b0;
      end else begin
         best             = span_max(0, leaves - 1, lo, hi, 0);
         answer.max_value = best[MAX_W-1:0];
         answer.range_ok  = 1'b1;
      end
      answer_q.insert(answer_q.size(), answer);
   endfunction

   always @(posedge clock) begin
      req_type          word;
      range_answer_type want;
      if (reset) begin
         foreach (node_max[i]) node_max[i] = '0;
         size_reg    = SIZE_W'(LEAF_MAX);
         error_count = 0;
         answer_q.delete();
      end else begin
         // results first: a word taken at this edge cannot have answered yet
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected result, expected none, got max_value %0d range_ok %0b",
                        $time, $signed(rsp_tdata), rsp_tuser[0]);
            end else begin
               want = answer_q.pop_front();
               if ($signed(rsp_tdata) !== want.max_value) begin
                  error_count++;
                  $display("%0t ns: max_value mismatch, expected %0d, got %0d",
                           $time, want.max_value, $signed(rsp_tdata));
               end
               if (rsp_tuser[0] !== want.range_ok) begin
                  error_count++;
                  $display("%0t ns: range_ok mismatch, expected %0b, got %0b",
                           $time, want.range_ok, rsp_tuser[0]);
               end
            end
         end
         // a word taken at this edge still sees the old size
         if (req_tvalid && req_tready) begin
            word.mode       = req_tuser[0];
            word.position   = req_tdata[0 +: IDX_W];
            word.new_value  = req_tdata[IDX_W +: VAL_W];
            word.range_low  = req_tdata[IDX_W+VAL_W +: IDX_W];
            word.range_high = req_tdata[2*IDX_W+VAL_W +: IDX_W];
            apply_word(word);
         end
         if (csr_valid && csr_ready) size_reg = csr_data;
      end
      pending_answers = answer_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives point writes, range queries and tree size changes into the segment
// tree unit under random back-pressure; the checker beside it predicts and
// compares every answer, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
   import rmst_pkg::*;
();

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int WALK_SETTLE   = 40;     // long enough for a trailing point write walk
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int TAIL_CYCLES   = 60;
   localparam int STALL_LIMIT   = 10000;  // covers the clearing pass after reset
   localparam int SEGMENTS      = 9;
   localparam int SEGMENT_WORDS = 100;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata  = '0;   // position, new_value, range_low, range_high, zero pad
   logic [0:0]        req_tuser  = '0;   // mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;         // max_value
   logic [0:0]        rsp_tuser;         // range_ok
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data   = '0;   // size_in_use

   int error_count;
   int pending_answers;
   int tx_idle_pct = 23;
   int rx_idle_pct = 60;
   int hold_seq    = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int quiet_run   = 0;

   always #(HALF_PERIOD) clock = ~clock;

   range_max_segment_tree_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   range_max_segment_tree_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_answers (pending_answers)
   );

   // Receiver: a new hold request starts a long stretch of tready low,
   // otherwise drop tready at the current idle rate.
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: count cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_run <= 0;
      else
         quiet_run <= quiet_run + 1;
      if (quiet_run >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one word from a falling edge and hold it until the unit takes it;
   // return at the falling edge after the handshake with tvalid still high,
   // so a following word goes out without a gap.
   task automatic send_word(input req_type word);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= word.mode;
      req_tdata  <= {3'b000, word.range_high, word.range_low, word.new_value, word.position};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic mode, input int unsigned position,
                              input logic [VAL_W-1:0] value,
                              input int unsigned low, input int unsigned high);
      req_type word;
      word.mode       = mode;
      word.position   = IDX_W'(position);
      word.new_value  = value;
      word.range_low  = IDX_W'(low);
      word.range_high = IDX_W'(high);
      send_word(word);
   endtask

   // Stop offering, wait for every answer, then let a trailing write walk finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_answers != 0) @(negedge clock);
      repeat (WALK_SETTLE) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] size);
      csr_valid <= 1'b1;
      csr_data  <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int unsigned leaves_for(input logic [SIZE_W-1:0] size);
      if (size == '0) return 1;
      if (size > SIZE_W'(LEAF_MAX)) return LEAF_MAX;
      return 32'(size);
   endfunction

   // Mostly well-formed words: writes inside the tree, queries over valid
   // ranges; the rest spread over every field value.
   function automatic req_type random_word(input int unsigned leaves, input bit force_query);
      req_type     word;
      logic [31:0] raw;
      int unsigned a;
      int unsigned b;
      int unsigned d;
      raw             = $urandom;
      word.new_value  = raw[VAL_W-1:0];
      word.position   = IDX_W'($urandom_range(LEAF_MAX - 1));
      word.range_low  = IDX_W'($urandom_range(LEAF_MAX - 1));
      word.range_high = IDX_W'($urandom_range(LEAF_MAX - 1));
      word.mode       = (force_query || $urandom_range(99) < 50) ? MODE_QUERY : MODE_WRITE;
      if (word.mode == MODE_WRITE) begin
         if ($urandom_range(99) < 88) word.position = IDX_W'($urandom_range(leaves - 1));
         case ($urandom_range(9))
            0:       word.new_value = '0;
            1:       word.new_value = '1;
            2, 3:    word.new_value = VAL_W'($urandom_range(255));
            default: ;
         endcase
      end else if ($urandom_range(99) < 85) begin
         a = $urandom_range(leaves - 1);
         b = $urandom_range(leaves - 1);
         d = $urandom_range(7);
         if ($urandom_range(99) < 30) b = (a + d < leaves) ? a + d : a;
         if (a > b) begin
            word.range_low  = IDX_W'(b);
            word.range_high = IDX_W'(a);
         end else begin
            word.range_low  = IDX_W'(a);
            word.range_high = IDX_W'(b);
         end
      end
      return word;
   endfunction

   initial begin
      logic [SIZE_W-1:0] seg_size [SEGMENTS];
      logic [SIZE_W-1:0] size;
      int unsigned       leaves;

      seg_size = '{11'd2, 11'd1024, 11'd7, 11'd1025, 11'd1023, 11'd513, 11'd0, 11'd1, 11'd3};
      seg_size[6] = SIZE_W'($urandom_range(LEAF_MAX, 1));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset size of 1024 leaves. Unused fields carry
      // all-ones or all-zeros so their bits move too.
      send_fields(MODE_WRITE, 0,    31'h7FFF_FFFF, 1023, 0);
      send_fields(MODE_WRITE, 1023, 31'd5,         0,    1023);
      send_fields(MODE_WRITE, 511,  31'd1234,      1023, 1023);
      send_fields(MODE_WRITE, 512,  31'd0,         0,    0);
      send_fields(MODE_QUERY, 1023, 31'h7FFF_FFFF, 0,    1023);   // whole tree
      send_fields(MODE_QUERY, 0,    31'd0,         1,    1023);
      send_fields(MODE_QUERY, 1023, 31'd0,         1023, 1023);   // last leaf alone
      send_fields(MODE_QUERY, 0,    31'h7FFF_FFFF, 512,  1022);
      send_fields(MODE_QUERY, 0,    31'd0,         5,    4);      // low above high
      send_fields(MODE_QUERY, 1023, 31'd0,         0,    0);

      // A zero size behaves as a single leaf.
      settle();
      write_size(11'd0);
      send_fields(MODE_WRITE, 0, 31'd77, 0, 0);
      send_fields(MODE_WRITE, 1, 31'd99, 0, 0);                   // outside the tree, ignored
      send_fields(MODE_QUERY, 0, 31'd0,  0, 0);
      send_fields(MODE_QUERY, 0, 31'd0,  0, 1);                   // high beyond the tree
      send_fields(MODE_QUERY, 0, 31'd0,  1, 1);

      // An oversize value behaves as the full tree; nodes keep what the
      // single-leaf shape left in them.
      settle();
      write_size(11'd2047);
      send_fields(MODE_QUERY, 0,    31'd0, 0,    1023);
      send_fields(MODE_WRITE, 1023, 31'd3, 0,    0);
      send_fields(MODE_QUERY, 0,    31'd0, 0,    1023);
      send_fields(MODE_QUERY, 0,    31'd0, 1000, 1023);

      // A size that is not a power of two.
      settle();
      write_size(11'd1000);
      send_fields(MODE_WRITE, 999,  31'h7FFF_FFFF, 0,    0);
      send_fields(MODE_WRITE, 1000, 31'd1,         0,    0);      // outside the tree, ignored
      send_fields(MODE_QUERY, 0,    31'd0,         0,    999);
      send_fields(MODE_QUERY, 0,    31'd0,         998,  999);
      send_fields(MODE_QUERY, 0,    31'd0,         0,    1000);
      send_fields(MODE_QUERY, 0,    31'd0,         1023, 1023);

      // Random segments, each at its own size; swap the idle rates after
      // three segments, then run the last three without idling.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) begin
            tx_idle_pct = 60;
            rx_idle_pct = 23;
         end else if (seg == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         settle();
         size   = seg_size[seg];
         leaves = leaves_for(size);
         write_size(size);
         // hold the receiver off while queries keep coming, so the unit backs up
         if (seg == 6) hold_seq = hold_seq + 1;
         for (int k = 0; k < SEGMENT_WORDS; k++) begin
            // pause the sender midway until every answer is in
            if (seg == 4 && k == SEGMENT_WORDS / 2) settle();
            send_word(random_word(leaves, seg == 6 && k < 12));
         end
      end

      // Drain, then give the unit time to show any stray result.
      req_tvalid <= 1'b0;
      while (pending_answers != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rmst_pkg.sv
src/rmst_node_ram.sv
src/rmst_walker.sv
src/range_max_segment_tree_unit.sv
tb/sv/range_max_segment_tree_checker.sv
tb/sv/tb_top.sv
